// File: src/ubuf_pkg.sv
// Package for the buffered UART transmit/receive ring block.
// Holds the request and status codes, line characters and default sizing.
// No dependencies.
package ubuf_pkg;

    // Default number of slots in each ring (one slot always stays free).
    localparam int DEFAULT_FIFO_DEPTH = 64;

    // Request codes carried by the mode field.
    localparam logic [2:0] MODE_PUT      = 3'd0;
    localparam logic [2:0] MODE_TEXT_PUT = 3'd1;
    localparam logic [2:0] MODE_GET      = 3'd2;
    localparam logic [2:0] MODE_TX_READY = 3'd3;
    localparam logic [2:0] MODE_LINE_RX  = 3'd4;

    // Status codes of a result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Line characters used by the text put.
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

endpackage

// File: src/ubuf_ram.sv
// Simple dual-port ring storage: one write port, one registered read port.
// Used for both the transmit and the receive ring. No package dependencies.
module ubuf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/uart_buffered_tx_rx_fifos_top.sv
// Top level of the buffered UART front end: transmit and receive rings.
// Depends on ubuf_pkg and ubuf_ram.
//
//   channel  ports                                       direction  role
//   s_       s_valid s_ready s_mode s_data_in            in         request
//   m_       m_valid m_ready m_status m_data_out         out        result
//            m_data_valid m_tx_request m_rx_available
//
// One request is taken every cycle unless the result is stalled; its result appears
// in the result register in the next cycle. All pointer checks and updates happen at
// the accepting edge, and ring reads land in each ram's read register with that result.
// A carriage return plus line feed takes two ring slots but one write: the
// stored word is flagged and the line feed is produced when its slot is popped.
// Reset (aresetn low, synchronous) empties both rings and clears the request
// flag. A stalled result blocks new requests only while m_ready is low.
module uart_buffered_tx_rx_fifos_top #(
    parameter int FIFO_DEPTH = ubuf_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_data_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_data_out,
    output logic       m_data_valid,
    output logic       m_tx_request,
    output logic       m_rx_available
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);

    // Source of the data byte in a result.
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_RX,
        SEL_TX,
        SEL_LF
    } dsel_t;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // State registers.
    logic [AW-1:0] tx_wp_reg, tx_wp_next;
    logic [AW-1:0] tx_rp_reg, tx_rp_next;
    logic [AW-1:0] rx_wp_reg, rx_wp_next;
    logic [AW-1:0] rx_rp_reg, rx_rp_next;
    logic          tx_irq_reg, tx_irq_next;
    logic          lf_sent_reg, lf_sent_next;

    // Result register.
    logic          m_valid_reg;
    logic [1:0]    status_reg, status_next;
    dsel_t         sel_reg, sel_next;
    logic          rx_avail_reg;

    // Ram ports.
    logic          tx_we, tx_re, rx_we, rx_re;
    logic [8:0]    tx_wdata, tx_rdata;
    logic [7:0]    rx_rdata;

    // Ring conditions.
    logic [AW-1:0] tx_wp1, tx_wp2, rx_wp1;
    logic          tx_empty, tx_full, tx_short, rx_empty, rx_full, lf_due;
    logic          accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    assign tx_wp1   = ptr_inc(tx_wp_reg);
    assign tx_wp2   = ptr_inc(tx_wp1);
    assign rx_wp1   = ptr_inc(rx_wp_reg);
    assign tx_empty = (tx_wp_reg == tx_rp_reg);
    assign tx_full  = (tx_wp1 == tx_rp_reg);
    assign tx_short = tx_full || (tx_wp2 == tx_rp_reg);
    assign rx_empty = (rx_wp_reg == rx_rp_reg);
    assign rx_full  = (rx_wp1 == rx_rp_reg);

    // The last popped word was a carriage return whose line feed is still owed.
    assign lf_due = tx_rdata[8] && !lf_sent_reg;

    // Request decode: status, pointer steps and ram accesses.
    always_comb begin
        tx_wp_next   = tx_wp_reg;
        tx_rp_next   = tx_rp_reg;
        rx_wp_next   = rx_wp_reg;
        rx_rp_next   = rx_rp_reg;
        tx_irq_next  = tx_irq_reg;
        lf_sent_next = lf_sent_reg;
        status_next  = ubuf_pkg::ST_OK;
        sel_next     = SEL_NONE;
        tx_we        = 1'b0;
        tx_re        = 1'b0;
        rx_we        = 1'b0;
        rx_re        = 1'b0;
        tx_wdata     = {1'b0, s_data_in};
        unique case (s_mode) inside
            ubuf_pkg::MODE_PUT, ubuf_pkg::MODE_TEXT_PUT: begin
                if (s_mode == ubuf_pkg::MODE_TEXT_PUT && s_data_in == ubuf_pkg::CHAR_LF) begin
                    if (tx_short) begin
                        status_next = ubuf_pkg::ST_FULL;
                    end else begin
                        tx_we       = accept;
                        tx_wdata    = {1'b1, ubuf_pkg::CHAR_CR};
                        tx_wp_next  = tx_wp2;
                        tx_irq_next = 1'b1;
                    end
                end else if (tx_full) begin
                    status_next = ubuf_pkg::ST_FULL;
                end else begin
                    tx_we       = accept;
                    tx_wp_next  = tx_wp1;
                    tx_irq_next = 1'b1;
                end
            end
            ubuf_pkg::MODE_GET: begin
                if (rx_empty) begin
                    status_next = ubuf_pkg::ST_EMPTY;
                end else begin
                    rx_re      = accept;
                    rx_rp_next = ptr_inc(rx_rp_reg);
                    sel_next   = SEL_RX;
                end
            end
            ubuf_pkg::MODE_TX_READY: begin
                if (tx_empty) begin
                    tx_irq_next = 1'b0;
                    status_next = ubuf_pkg::ST_EMPTY;
                end else begin
                    tx_rp_next = ptr_inc(tx_rp_reg);
                    if (lf_due) begin
                        sel_next     = SEL_LF;
                        lf_sent_next = 1'b1;
                    end else begin
                        tx_re        = accept;
                        sel_next     = SEL_TX;
                        lf_sent_next = 1'b0;
                    end
                end
            end
            ubuf_pkg::MODE_LINE_RX: begin
                if (rx_full) begin
                    status_next = ubuf_pkg::ST_FULL;
                end else begin
                    rx_we      = accept;
                    rx_wp_next = rx_wp1;
                end
            end
            default: begin
            end
        endcase
    end

    // State and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_wp_reg    <= '0;
            tx_rp_reg    <= '0;
            rx_wp_reg    <= '0;
            rx_rp_reg    <= '0;
            tx_irq_reg   <= 1'b0;
            lf_sent_reg  <= 1'b1;
            m_valid_reg  <= 1'b0;
            status_reg   <= ubuf_pkg::ST_OK;
            sel_reg      <= SEL_NONE;
            rx_avail_reg <= 1'b0;
        end else if (accept) begin
            tx_wp_reg    <= tx_wp_next;
            tx_rp_reg    <= tx_rp_next;
            rx_wp_reg    <= rx_wp_next;
            rx_rp_reg    <= rx_rp_next;
            tx_irq_reg   <= tx_irq_next;
            lf_sent_reg  <= lf_sent_next;
            m_valid_reg  <= 1'b1;
            status_reg   <= status_next;
            sel_reg      <= sel_next;
            rx_avail_reg <= (rx_wp_next != rx_rp_next);
        end else if (m_ready) begin
            m_valid_reg  <= 1'b0;
        end
    end

    // Transmit ring storage: a flag bit marks a carriage return with a line feed behind it.
    ubuf_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (9)
    ) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_we),
        .wr_addr (tx_wp_reg),
        .wr_data (tx_wdata),
        .rd_en   (tx_re),
        .rd_addr (tx_rp_reg),
        .rd_data (tx_rdata)
    );

    // Receive ring storage.
    ubuf_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_we),
        .wr_addr (rx_wp_reg),
        .wr_data (s_data_in),
        .rd_en   (rx_re),
        .rd_addr (rx_rp_reg),
        .rd_data (rx_rdata)
    );

    // Result outputs.
    always_comb begin
        case (sel_reg)
            SEL_RX:  m_data_out = rx_rdata;
            SEL_TX:  m_data_out = tx_rdata[7:0];
            SEL_LF:  m_data_out = ubuf_pkg::CHAR_LF;
            default: m_data_out = 8'h00;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_data_valid   = (sel_reg != SEL_NONE);
    assign m_tx_request   = tx_irq_reg;
    assign m_rx_available = rx_avail_reg;

`ifndef SYNTHESIS
    // A popped byte always comes with an ok status.
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_valid |-> m_status == ubuf_pkg::ST_OK)
        else $error("popped byte reported with a non-ok status");

    // Pushing or dropping a line byte both leave the receive ring non-empty.
    a_rx_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_mode == ubuf_pkg::MODE_LINE_RX |=> m_rx_available)
        else $error("receive ring reported empty after a line byte");

    // A host put, taken or refused, leaves the transmit request raised.
    a_put_request: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_mode == ubuf_pkg::MODE_PUT || s_mode == ubuf_pkg::MODE_TEXT_PUT)
        |=> m_tx_request)
        else $error("transmit request low after a host put");

    // An empty transmit ring seen by the transmitter drops the request.
    a_tx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_mode == ubuf_pkg::MODE_TX_READY && tx_empty
        |=> !m_tx_request && m_status == ubuf_pkg::ST_EMPTY)
        else $error("transmit request kept on an empty ring");

    // A line feed is owed only while the transmit ring still holds its slot.
    a_lf_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        lf_due |-> !tx_empty)
        else $error("line feed owed with an empty transmit ring");
`endif

endmodule
